[rtl/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Slot count, field widths, operation and result codes, controller interface.
// ----------------------------------------------------------------------------
package stq_pkg;
    localparam int SLOTS = 16;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [39:0] EXP_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ADD_PER = 2'd0, OP_ADD_ONE = 2'd1, OP_CANCEL = 2'd2, OP_TICK = 2'd3
    } op_t;
    typedef enum logic [1:0] {
        K_FIRED = 2'd0, K_TICK = 2'd1, K_ACC = 2'd2, K_REJ = 2'd3
    } kind_t;
    // S_SCAN: dispatch, cancel scan, tick head check
    // S_SHIFT: insert scan for add and re-arm
    // S_FIRE: wait for a fired result to leave
    // S_OUT: wait for the final result to leave
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_FIRE, S_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture request, start at index 0
        logic step;      // advance scan index
        logic write_new; // insert new entry at index, shift tail up
        logic remove;    // remove slot at index, shift tail down
        logic pop_head;  // remove head, capture it for re-arm
        logic tick_now;  // advance seconds
        logic out_load;  // load output register
    } cmd_t;

    typedef struct packed {
        logic idx_at_end;   // index reached count
        logic ins_here;     // new expiry < slot[idx]
        logic match;        // cancel match at idx
        logic full;
        logic zero_per;
        logic head_due;
        logic fired_lim;
        logic repost;       // head entry is periodic
    } stat_t;
endpackage

[rtl/stq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_datapath: slot table, seconds counter and result register
// Scans walk one slot per cycle; insert and remove shift the table at once.
// ----------------------------------------------------------------------------
module stq_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           s_operation,
    input  logic [15:0]          s_handler,
    input  logic [31:0]          s_tag,
    input  logic                 s_any_tag,
    input  logic [31:0]          s_delay,
    input  stq_pkg::cmd_t        cmd,
    input  logic [1:0]           out_kind,
    input  logic                 out_last,
    output stq_pkg::stat_t       stat,
    output logic [1:0]           m_kind,
    output logic [15:0]          m_fired_handler,
    output logic [31:0]          m_fired_tag,
    output logic [39:0]          m_next_expiry,
    output logic [4:0]           m_removed_count,
    output logic                 m_last
);
    logic [39:0] exp_reg [stq_pkg::SLOTS];
    logic [31:0] per_reg [stq_pkg::SLOTS];
    logic [15:0] hnd_reg [stq_pkg::SLOTS];
    logic [31:0] tag_reg [stq_pkg::SLOTS];
    logic [stq_pkg::CW-1:0] count_reg, idx_reg, rem_reg, fired_reg;
    logic [39:0] now_reg, new_exp_reg;
    logic [31:0] new_per_reg, new_tag_reg;
    logic [15:0] new_hnd_reg;
    logic [1:0]  op_reg;
    logic        any_reg;
    logic [31:0] add_src;
    logic [40:0] sum;
    logic [39:0] sum_sat;
    logic [39:0] now_next;
    logic [stq_pkg::IW-1:0] ix, rm_pos;

    assign ix = idx_reg[stq_pkg::IW-1:0];
    assign rm_pos = cmd.pop_head ? '0 : ix;
    assign now_next = (now_reg == stq_pkg::EXP_MAX) ? now_reg : now_reg + 40'd1;
    // add uses the request delay, re-arm the popped period
    assign add_src = cmd.pop_head ? per_reg[0] : s_delay;
    assign sum = {1'b0, now_reg} + {9'd0, add_src};
    assign sum_sat = sum[40] ? stq_pkg::EXP_MAX : sum[39:0];

    always_comb begin
        stat.idx_at_end = (idx_reg == count_reg);
        stat.ins_here   = !stat.idx_at_end && (new_exp_reg < exp_reg[ix]);
        stat.match      = !stat.idx_at_end && hnd_reg[ix] == new_hnd_reg
                          && (any_reg || tag_reg[ix] == new_tag_reg);
        stat.full       = (count_reg == stq_pkg::CW'(stq_pkg::SLOTS));
        stat.zero_per   = (op_reg == stq_pkg::OP_ADD_PER) && (new_per_reg == 32'd0);
        stat.head_due   = (count_reg != '0) && !(now_reg < exp_reg[0]);
        stat.fired_lim  = (fired_reg == stq_pkg::CW'(stq_pkg::SLOTS));
        stat.repost     = (per_reg[0] != 32'd0);
    end

    // slot table
    always_ff @(posedge aclk) begin
        if (cmd.write_new) begin
            for (int i = 1; i < stq_pkg::SLOTS; i++) begin
                if (stq_pkg::IW'(i) > ix) begin
                    exp_reg[i] <= exp_reg[i-1];
                    per_reg[i] <= per_reg[i-1];
                    hnd_reg[i] <= hnd_reg[i-1];
                    tag_reg[i] <= tag_reg[i-1];
                end
            end
            exp_reg[ix] <= new_exp_reg;
            per_reg[ix] <= new_per_reg;
            hnd_reg[ix] <= new_hnd_reg;
            tag_reg[ix] <= new_tag_reg;
        end else if (cmd.remove || cmd.pop_head) begin
            for (int i = 0; i < stq_pkg::SLOTS - 1; i++) begin
                if (stq_pkg::IW'(i) >= rm_pos) begin
                    exp_reg[i] <= exp_reg[i+1];
                    per_reg[i] <= per_reg[i+1];
                    hnd_reg[i] <= hnd_reg[i+1];
                    tag_reg[i] <= tag_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            now_reg   <= '0;
            m_kind    <= stq_pkg::K_ACC;
            m_last    <= 1'b0;
        end else begin
            if (cmd.load) begin
                op_reg <= s_operation;
                any_reg <= s_any_tag;
                new_hnd_reg <= s_handler;
                new_tag_reg <= s_tag;
                new_per_reg <= (s_operation == stq_pkg::OP_ADD_PER) ? s_delay : 32'd0;
                new_exp_reg <= sum_sat;
                idx_reg <= '0;
                rem_reg <= '0;
                fired_reg <= '0;
            end
            if (cmd.tick_now) now_reg <= now_next;
            if (cmd.step) idx_reg <= idx_reg + 1'b1;
            if (cmd.pop_head) begin
                new_hnd_reg <= hnd_reg[0];
                new_tag_reg <= tag_reg[0];
                new_per_reg <= per_reg[0];
                new_exp_reg <= sum_sat;
                idx_reg <= '0;
                fired_reg <= fired_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.remove) begin
                count_reg <= count_reg - 1'b1;
                rem_reg <= rem_reg + 1'b1;
            end
            if (cmd.write_new) count_reg <= count_reg + 1'b1;
            if (cmd.out_load) begin
                m_kind <= out_kind;
                m_last <= out_last;
                m_fired_handler <= (out_kind == stq_pkg::K_FIRED) ? hnd_reg[0] : 16'd0;
                m_fired_tag <= (out_kind == stq_pkg::K_FIRED) ? tag_reg[0] : 32'd0;
                m_next_expiry <= (out_kind == stq_pkg::K_TICK && count_reg != '0)
                                 ? exp_reg[0] : 40'd0;
                m_removed_count <= (out_kind == stq_pkg::K_ACC) ? 5'(rem_reg) : 5'd0;
            end
        end
    end
endmodule

[rtl/stq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl: sequencer of the sorted timer queue
// Walks scans, table updates and output handshakes one step per cycle.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_operation,
    output logic           m_valid,
    input  logic           m_ready,
    input  stq_pkg::stat_t stat,
    output stq_pkg::cmd_t  cmd,
    output logic [1:0]     out_kind,
    output logic           out_last
);
    stq_pkg::state_t state_reg, state_next;
    stq_pkg::op_t    op_reg;
    logic            m_valid_reg, m_valid_next;
    logic            accept;

    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    // result register is always empty in idle
    assign s_ready = (state_reg == stq_pkg::S_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::S_IDLE: if (accept) state_next = stq_pkg::S_SCAN;
            stq_pkg::S_SCAN: begin
                unique case (op_reg)
                    stq_pkg::OP_ADD_PER, stq_pkg::OP_ADD_ONE: begin
                        state_next = (stat.full || stat.zero_per)
                                     ? stq_pkg::S_OUT : stq_pkg::S_SHIFT;
                    end
                    stq_pkg::OP_CANCEL: if (stat.idx_at_end) state_next = stq_pkg::S_OUT;
                    stq_pkg::OP_TICK: begin
                        if (stat.head_due && !stat.fired_lim)
                            state_next = stat.repost ? stq_pkg::S_SHIFT : stq_pkg::S_FIRE;
                        else
                            state_next = stq_pkg::S_OUT;
                    end
                endcase
            end
            stq_pkg::S_SHIFT: if (stat.ins_here || stat.idx_at_end) begin
                state_next = (op_reg == stq_pkg::OP_TICK) ? stq_pkg::S_FIRE : stq_pkg::S_OUT;
            end
            stq_pkg::S_FIRE: if (!m_valid_reg || m_ready) state_next = stq_pkg::S_SCAN;
            stq_pkg::S_OUT: if (m_ready) state_next = stq_pkg::S_IDLE;
            default: state_next = stq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        out_kind = stq_pkg::K_ACC;
        out_last = 1'b1;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            stq_pkg::S_IDLE: begin
                cmd.load = accept;
                cmd.tick_now = accept && (s_operation == stq_pkg::OP_TICK);
            end
            stq_pkg::S_SCAN: begin
                unique case (op_reg)
                    stq_pkg::OP_ADD_PER, stq_pkg::OP_ADD_ONE: begin
                        if (stat.full || stat.zero_per) begin
                            cmd.out_load = 1'b1;
                            out_kind = stq_pkg::K_REJ;
                        end
                    end
                    stq_pkg::OP_CANCEL: begin
                        priority if (stat.idx_at_end) cmd.out_load = 1'b1;
                        else if (stat.match) cmd.remove = 1'b1;
                        else cmd.step = 1'b1;
                    end
                    stq_pkg::OP_TICK: begin
                        cmd.out_load = 1'b1;
                        if (stat.head_due && !stat.fired_lim) begin
                            cmd.pop_head = 1'b1;
                            out_kind = stq_pkg::K_FIRED;
                            out_last = 1'b0;
                        end else begin
                            out_kind = stq_pkg::K_TICK;
                        end
                    end
                endcase
            end
            stq_pkg::S_SHIFT: begin
                if (stat.ins_here || stat.idx_at_end) begin
                    cmd.write_new = 1'b1;
                    cmd.out_load = (op_reg != stq_pkg::OP_TICK);
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: ;
        endcase
        if (cmd.out_load) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            op_reg <= stq_pkg::OP_ADD_PER;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (cmd.load) op_reg <= stq_pkg::op_t'(s_operation);
        end
    end
endmodule

[rtl/sorted_timer_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_top: sorted table of one-shot and periodic timers
// Sequencer plus slot datapath; one request at a time.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// s_       | s_valid / s_ready  | operation handler tag any_tag delay
// m_       | m_valid / m_ready  | kind fired_handler fired_tag next_expiry
//          |                    | removed_count last
// Add: a check step, then a scan of one slot per cycle; the insert lands on
//   the first later expiry. Rejects load at the check, accepts at the insert.
// Cancel: one slot per cycle, a match removed without stepping the index.
//   Next request in the cycle after the result handshake.
// Tick: per fired entry a pop, a re-arm scan if periodic and a wait
//   for the fired result to leave.
// Reset covers the seconds counter, fill count, sequencer and m_kind/m_last.
// A stalled result holds the sequencer; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_handler,
    input  logic [31:0] s_tag,
    input  logic        s_any_tag,
    input  logic [31:0] s_delay,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_fired_handler,
    output logic [31:0] m_fired_tag,
    output logic [39:0] m_next_expiry,
    output logic [4:0]  m_removed_count,
    output logic        m_last
);
    stq_pkg::cmd_t  cmd;
    stq_pkg::stat_t stat;
    logic [1:0] out_kind;
    logic       out_last;

    stq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd), .out_kind(out_kind), .out_last(out_last)
    );

    stq_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_operation(s_operation),
        .s_handler(s_handler), .s_tag(s_tag), .s_any_tag(s_any_tag),
        .s_delay(s_delay), .cmd(cmd), .out_kind(out_kind), .out_last(out_last),
        .stat(stat), .m_kind(m_kind), .m_fired_handler(m_fired_handler),
        .m_fired_tag(m_fired_tag), .m_next_expiry(m_next_expiry),
        .m_removed_count(m_removed_count), .m_last(m_last)
    );
endmodule

[sim/stq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker: scoreboard for the sorted timer queue
// Mirrors the timer table on every accepted request, queues the expected
// results and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module stq_checker
    import stq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_handler,
    input  logic [31:0] s_tag,
    input  logic        s_any_tag,
    input  logic [31:0] s_delay,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [15:0] m_fired_handler,
    input  logic [31:0] m_fired_tag,
    input  logic [39:0] m_next_expiry,
    input  logic [4:0]  m_removed_count,
    input  logic        m_last,
    output int          errors,
    output int          pending,
    output int          fired_seen,
    output int          rejects_seen
);
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] hnd;
        logic [31:0] tag;
        logic [39:0] nxt;
        logic [4:0]  rem;
        logic        last;
    } res_t;

    typedef struct {
        logic [39:0] expiry;
        logic [31:0] period;
        logic [15:0] hnd;
        logic [31:0] tag;
    } timer_t;

    timer_t      timers[$];
    logic [39:0] now_sec;
    res_t        expected_q[$];

    function automatic logic [39:0] sat_sum(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? EXP_MAX : s[39:0];
    endfunction

    // stable sorted insert: after every entry with expiry <= when
    function automatic void arm_timer(logic [39:0] when, logic [31:0] per,
                                      logic [15:0] h, logic [31:0] t);
        timer_t e;
        int pos;
        e.expiry = when; e.period = per; e.hnd = h; e.tag = t;
        pos = 0;
        while (pos < timers.size() && !(when < timers[pos].expiry)) pos++;
        timers.insert(pos, e);
    endfunction

    function automatic res_t mk(logic [1:0] k, logic [15:0] h, logic [31:0] t,
                                logic [39:0] nx, logic [4:0] r, logic l);
        res_t x;
        x.kind = k; x.hnd = h; x.tag = t; x.nxt = nx; x.rem = r; x.last = l;
        return x;
    endfunction

    function automatic void predict_request(op_t op, logic [15:0] h,
                                            logic [31:0] t, logic any,
                                            logic [31:0] d);
        int i, removed, fired;
        timer_t head;
        case (op)
            OP_ADD_PER, OP_ADD_ONE: begin
                if (timers.size() >= SLOTS || (op == OP_ADD_PER && d == 0)) begin
                    expected_q.push_back(mk(K_REJ, 0, 0, 0, 0, 1));
                end else begin
                    arm_timer(sat_sum(now_sec, {8'd0, d}),
                              (op == OP_ADD_PER) ? d : 32'd0, h, t);
                    expected_q.push_back(mk(K_ACC, 0, 0, 0, 0, 1));
                end
            end
            OP_CANCEL: begin
                i = 0; removed = 0;
                while (i < timers.size()) begin
                    if (timers[i].hnd == h && (any || timers[i].tag == t)) begin
                        timers.delete(i);
                        removed++;
                    end else i++;
                end
                expected_q.push_back(mk(K_ACC, 0, 0, 0, removed[4:0], 1));
            end
            default: begin
                fired = 0;
                now_sec = sat_sum(now_sec, 40'd1);
                while (timers.size() > 0 && fired < SLOTS
                       && !(now_sec < timers[0].expiry)) begin
                    head = timers.pop_front();
                    if (head.period != 0)
                        arm_timer(sat_sum(now_sec, {8'd0, head.period}),
                                  head.period, head.hnd, head.tag);
                    expected_q.push_back(mk(K_FIRED, head.hnd, head.tag, 0, 0, 0));
                    fired++;
                end
                expected_q.push_back(mk(K_TICK, 0, 0,
                    (timers.size() > 0) ? timers[0].expiry : 40'd0, 0, 1));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        res_t exp_r;
        if (!aresetn) begin
            timers.delete();
            expected_q.delete();
            now_sec = '0;
            errors = 0;
            fired_seen <= 0;
            rejects_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result kind", 40'(m_kind), 40'd0);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_kind != exp_r.kind)
                        report_mismatch("kind", 40'(m_kind), 40'(exp_r.kind));
                    if (m_fired_handler != exp_r.hnd)
                        report_mismatch("fired_handler", 40'(m_fired_handler),
                                        40'(exp_r.hnd));
                    if (m_fired_tag != exp_r.tag)
                        report_mismatch("fired_tag", 40'(m_fired_tag), 40'(exp_r.tag));
                    if (m_next_expiry != exp_r.nxt)
                        report_mismatch("next_expiry", m_next_expiry, exp_r.nxt);
                    if (m_removed_count != exp_r.rem)
                        report_mismatch("removed_count", 40'(m_removed_count),
                                        40'(exp_r.rem));
                    if (m_last != exp_r.last)
                        report_mismatch("last", 40'(m_last), 40'(exp_r.last));
                    if (exp_r.kind == K_FIRED) fired_seen <= fired_seen + 1;
                    if (exp_r.kind == K_REJ) rejects_seen <= rejects_seen + 1;
                end
            end
            if (s_valid && s_ready)
                predict_request(op_t'(s_operation), s_handler, s_tag, s_any_tag, s_delay);
        end
        pending <= expected_q.size();
    end
endmodule

[sim/tb_sorted_timer_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue_top: testbench of the sorted timer queue
// Directed corners (full table, zero period, large delays, cancel forms) then
// random timer traffic with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue_top;
    import stq_pkg::*;

    localparam longint LIMIT = 1500000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [15:0] s_handler = '0;
    logic [31:0] s_tag = '0;
    logic        s_any_tag = 1'b0;
    logic [31:0] s_delay = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_fired_handler;
    logic [31:0] m_fired_tag;
    logic [39:0] m_next_expiry;
    logic [4:0]  m_removed_count;
    logic        m_last;

    int     errors, pending, fired_seen, rejects_seen;
    int     requests_sent;
    longint cycle_cnt;
    bit     hold_off;   // receiver long stall window
    bit     drain_idle; // receiver stays ready during the drain

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_timer_queue_top u_top (.*);

    stq_checker u_chk (.*);

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL sorted_timer_queue_top");
            $finish;
        end
    end
    initial cycle_cnt = 0;

    // Result side: random stall per result, plus a long hold-off window
    // the stimulus can ask for; some stretches run with no stall at all.
    initial begin
        int wait_n;
        bit burst;
        burst = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                if ($urandom_range(0, 15) == 0) burst = ~burst;
                wait_n = (burst || drain_idle) ? 0 : int'($urandom_range(0, 11));
                if (wait_n > 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_n - 1) @(posedge aclk);
                    @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Send one request; waits a random gap first, then holds until accepted.
    // Valid stays up after acceptance until the next gap or drain.
    task automatic send_request(op_t op, logic [15:0] h, logic [31:0] t,
                                logic any, logic [31:0] d, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_handler   <= h;
        s_tag       <= t;
        s_any_tag   <= any;
        s_delay     <= d;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int i, r;
        logic [15:0] h;
        logic [31:0] t, d;
        hold_off = 1'b0;
        drain_idle = 1'b0;
        requests_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty tick, zero period, empty cancel
        send_request(OP_TICK, 0, 0, 0, 0);
        send_request(OP_ADD_PER, 16'h1234, 32'h1, 0, 0);
        send_request(OP_CANCEL, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
        // equal expiries keep arming order; extremes of fields
        send_request(OP_ADD_ONE, 16'hFFFF, 32'hFFFF_FFFF, 0, 1);
        send_request(OP_ADD_ONE, 16'h0000, 32'h0000_0000, 0, 1);
        send_request(OP_ADD_PER, 16'hAAAA, 32'h5555_5555, 0, 1);
        send_request(OP_ADD_ONE, 16'h5555, 32'hAAAA_AAAA, 1, 0);
        send_request(OP_TICK, 0, 0, 0, 0);
        send_request(OP_TICK, 0, 0, 0, 0);
        // fill the table past full while the receiver is held off,
        // so the block backs up and stalls its input
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (i = 0; i < 17; i++)
                send_request(OP_ADD_ONE, 16'h0007, 32'(i), 0, 32'hFFFF_FFFF - i, 1);
        join
        // cancel by tag, then by any tag
        send_request(OP_CANCEL, 16'h0007, 32'd3, 0, 0);
        send_request(OP_CANCEL, 16'h0007, 32'd9, 1, 0);
        send_request(OP_CANCEL, 16'hAAAA, 0, 1, 0);
        send_request(OP_TICK, 0, 0, 0, 0);
        // sender pauses until everything has come back
        wait_drained();

        // Random traffic: mostly small delays on a few handlers so timers
        // actually fire and cancels actually hit.
        for (i = 0; i < 195; i++) begin
            r = $urandom_range(0, 99);
            h = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
            t = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
            d = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
            if (r < 30)
                send_request(OP_ADD_ONE, h, t, 1'($urandom_range(0, 1)), d, i % 40 < 5);
            else if (r < 55)
                send_request(OP_ADD_PER, h, t, 1'($urandom_range(0, 1)), d, i % 40 < 5);
            else if (r < 65)
                send_request(OP_CANCEL, h, t, 1'($urandom_range(0, 1)), $urandom);
            else
                send_request(OP_TICK, h, t, 1'($urandom_range(0, 1)), $urandom);
            if (i == 120) wait_drained();
        end

        // Largest periods: these entries expire far beyond any tick here.
        send_request(OP_CANCEL, 0, 0, 1, 0);
        for (i = 0; i < 4; i++)
            send_request(OP_ADD_PER, 16'hBEEF, 32'(i), 0, 32'hFFFF_FFFF);
        send_request(OP_TICK, 0, 0, 0, 0);

        wait_drained();
        drain_idle = 1'b1;
        repeat (400) @(posedge aclk);

        $display("covered %0d requests: %0d timers fired, %0d adds rejected",
                 requests_sent, fired_seen, rejects_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASS sorted_timer_queue_top");
        end else begin
            $display("FAIL sorted_timer_queue_top");
        end
        $finish;
    end
endmodule
